/* design/ttcc_pkg.sv */
// Package for the text terminal cursor control unit.
// Holds the character codes, configuration register indexes and shared structs.
// No dependencies.
package ttcc_pkg;

  // Field widths fixed by the character stream and the screen coordinates.
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Printable range and control characters.
  localparam logic [CHAR_W-1:0] PRINT_LOW      = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HIGH     = 8'h7F;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LINE_FEED = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_BEFORE_DRAW = 2'd2;

  // Configuration register reset values.
  localparam logic [POS_W-1:0] LAST_COLUMN_RST = 8'd79;
  localparam logic [POS_W-1:0] LAST_ROW_RST    = 8'd24;

  // Current screen configuration.
  typedef struct packed {
    logic [POS_W-1:0] last_column;
    logic [POS_W-1:0] last_row;
    logic             clear_before_draw;
  } ttcc_cfg_t;

  // One result transaction, including the cursor after the byte.
  typedef struct packed {
    logic              draw_glyph;
    logic [CHAR_W-1:0] glyph_code;
    logic              clear_cell;
    logic [POS_W-1:0]  target_column;
    logic [POS_W-1:0]  target_row;
    logic              scroll_up;
    logic [POS_W-1:0]  cursor_column;
    logic [POS_W-1:0]  cursor_row;
  } ttcc_result_t;

endpackage

/* design/ttcc_step.sv */
// Combinational cursor update for one character byte.
// Depends on ttcc_pkg for codes, the configuration struct and the result struct.
module ttcc_step #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic [ttcc_pkg::CHAR_W-1:0] char_code,
  input  logic [ttcc_pkg::POS_W-1:0]  column_now,
  input  logic [ttcc_pkg::POS_W-1:0]  row_now,
  input  ttcc_pkg::ttcc_cfg_t         cfg,
  output ttcc_pkg::ttcc_result_t      result
);

  // Remainder width: holds any remainder below the tab stop.
  localparam int unsigned REM_W = $clog2(TAB_STOP) + 1;
  localparam int unsigned WIDE_W = ttcc_pkg::POS_W + 1;

  // The column is divided by the tab stop through a scaled reciprocal.
  // The rounding error stays below one quotient step for every 8-bit column.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = ttcc_pkg::POS_W + RECIP_SHIFT;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + TAB_STOP - 1) / TAB_STOP;

  logic                       is_print;
  logic [WIDE_W-1:0]          col_w;
  logic [WIDE_W-1:0]          row_w;
  logic [REM_W-1:0]           rem;
  logic [PROD_W-1:0]          quot_prod;
  logic [PROD_W-1:0]          quot_back;
  logic [ttcc_pkg::POS_W-1:0] rem_full;

  // Column modulo the tab stop: quotient by reciprocal, then subtract it back out.
  assign quot_prod = PROD_W'(column_now) * PROD_W'(RECIP);
  assign quot_back = PROD_W'(quot_prod[PROD_W-1:RECIP_SHIFT]) * PROD_W'(TAB_STOP);
  assign rem_full  = column_now - quot_back[ttcc_pkg::POS_W-1:0];
  assign rem       = rem_full[REM_W-1:0];

  // Move the cursor for the byte, then wrap the column and saturate the row.
  always_comb begin
    is_print = (char_code >= ttcc_pkg::PRINT_LOW) && (char_code <= ttcc_pkg::PRINT_HIGH);
    col_w    = {1'b0, column_now};
    row_w    = {1'b0, row_now};
    result   = '0;
    result.glyph_code = char_code;

    // Any byte that is neither printable nor a known control moves nothing.
    if (is_print) begin
      result.draw_glyph    = 1'b1;
      result.clear_cell    = cfg.clear_before_draw;
      result.target_column = column_now;
      result.target_row    = row_now;
      col_w = col_w + WIDE_W'(1);
    end else if (char_code == ttcc_pkg::CODE_LINE_FEED) begin
      col_w = '0;
      row_w = row_w + WIDE_W'(1);
    end else if (char_code == ttcc_pkg::CODE_RETURN) begin
      col_w = '0;
    end else if (char_code == ttcc_pkg::CODE_BACKSPACE) begin
      if (column_now != '0) begin
        col_w = col_w - WIDE_W'(1);
      end else if (row_now != '0) begin
        row_w = row_w - WIDE_W'(1);
        col_w = {1'b0, cfg.last_column};
      end
    end else if (char_code == ttcc_pkg::CODE_TAB) begin
      col_w = col_w + (WIDE_W'(TAB_STOP) - WIDE_W'(rem));
    end

    // A column past the right edge wraps to the next row.
    if (col_w > {1'b0, cfg.last_column}) begin
      col_w = '0;
      row_w = row_w + WIDE_W'(1);
    end
    // A row past the bottom holds on the last row and scrolls.
    if (row_w > {1'b0, cfg.last_row}) begin
      row_w = {1'b0, cfg.last_row};
      result.scroll_up = 1'b1;
    end

    // Backspace clears the cell under the new cursor.
    if (char_code == ttcc_pkg::CODE_BACKSPACE) begin
      result.clear_cell    = 1'b1;
      result.target_column = col_w[ttcc_pkg::POS_W-1:0];
      result.target_row    = row_w[ttcc_pkg::POS_W-1:0];
    end

    result.cursor_column = col_w[ttcc_pkg::POS_W-1:0];
    result.cursor_row    = row_w[ttcc_pkg::POS_W-1:0];
  end

endmodule

/* design/text_terminal_cursor_control_unit.sv */
// Top level of the text terminal cursor control unit.
// Depends on ttcc_pkg and ttcc_step.
//
// Takes one character byte per transaction and returns one result transaction per byte:
// the glyph to draw or the cell to clear, a scroll request, and the cursor after the byte.
// The unit sustains one byte per clock cycle while the receiver does not stall. A byte is
// captured in the input register; once the result register can load, the cursor update is
// computed in a single combinational pass and loaded into the result register together
// with the cursor registers, so the following byte already sees the new cursor. While a
// result waits to be taken, one more byte can be held in the input register.
// Configuration writes are always ready and should be made while no byte is in flight.
module text_terminal_cursor_control_unit #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Character input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ttcc_pkg::CHAR_W-1:0]    in_char_code,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_draw_glyph,
  output logic [ttcc_pkg::CHAR_W-1:0]    out_glyph_code,
  output logic                           out_clear_cell,
  output logic [ttcc_pkg::POS_W-1:0]     out_target_column,
  output logic [ttcc_pkg::POS_W-1:0]     out_target_row,
  output logic                           out_scroll_up,
  output logic [ttcc_pkg::POS_W-1:0]     out_cursor_column,
  output logic [ttcc_pkg::POS_W-1:0]     out_cursor_row,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttcc_pkg::POS_W-1:0]     cfg_data
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [ttcc_pkg::CHAR_W-1:0] s1_code_r;
  logic                        out_valid_r, out_valid_nxt;
  ttcc_pkg::ttcc_result_t      out_r;
  logic [ttcc_pkg::POS_W-1:0]  column_r;
  logic [ttcc_pkg::POS_W-1:0]  row_r;
  ttcc_pkg::ttcc_cfg_t         cfg_r;
  ttcc_pkg::ttcc_result_t      step_result;
  logic                        in_accept;
  logic                        out_load;
  logic                        s1_advance;

  // Handshake control: the result register loads when empty or being taken.
  assign out_load   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_load;
  assign in_stall   = s1_valid_r && !out_load;
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code_r <= in_char_code;
    end
    if (s1_advance) begin
      out_r <= step_result;
    end
  end

  // Cursor update for the byte in the input register.
  ttcc_step #(
    .TAB_STOP (TAB_STOP)
  ) u_step (
    .char_code  (s1_code_r),
    .column_now (column_r),
    .row_now    (row_r),
    .cfg        (cfg_r),
    .result     (step_result)
  );

  // Cursor position moves with each byte that enters the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else if (s1_advance) begin
      column_r <= step_result.cursor_column;
      row_r    <= step_result.cursor_row;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.last_column       <= ttcc_pkg::LAST_COLUMN_RST;
      cfg_r.last_row          <= ttcc_pkg::LAST_ROW_RST;
      cfg_r.clear_before_draw <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttcc_pkg::CFG_LAST_COLUMN:       cfg_r.last_column       <= cfg_data;
        ttcc_pkg::CFG_LAST_ROW:          cfg_r.last_row          <= cfg_data;
        ttcc_pkg::CFG_CLEAR_BEFORE_DRAW: cfg_r.clear_before_draw <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Result ports.
  assign out_valid         = out_valid_r;
  assign out_draw_glyph    = out_r.draw_glyph;
  assign out_glyph_code    = out_r.glyph_code;
  assign out_clear_cell    = out_r.clear_cell;
  assign out_target_column = out_r.target_column;
  assign out_target_row    = out_r.target_row;
  assign out_scroll_up     = out_r.scroll_up;
  assign out_cursor_column = out_r.cursor_column;
  assign out_cursor_row    = out_r.cursor_row;

`ifndef SYNTHESIS
  // The cursor registers always match the cursor of the pending result.
  a_cursor_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (column_r == out_r.cursor_column) && (row_r == out_r.cursor_row))
    else $error("cursor registers differ from the pending result");

  // A glyph is drawn only for a printable byte.
  a_draw_is_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.draw_glyph) |->
      (out_r.glyph_code >= ttcc_pkg::PRINT_LOW) && (out_r.glyph_code <= ttcc_pkg::PRINT_HIGH))
    else $error("glyph drawn for a non-printable byte");

  // A clear without a draw comes only from backspace.
  a_clear_only_backspace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clear_cell && !out_r.draw_glyph) |->
      (out_r.glyph_code == ttcc_pkg::CODE_BACKSPACE))
    else $error("cell cleared for a byte other than backspace");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the text terminal cursor control unit.
// Depends on ttcc_pkg and the text_terminal_cursor_control_unit RTL, which also needs ttcc_step.
// A scoreboard tracks the cursor itself and checks every result transaction field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAR_W        = ttcc_pkg::CHAR_W;
  localparam int unsigned POS_W         = ttcc_pkg::POS_W;
  localparam int unsigned CFG_IDX_W     = ttcc_pkg::CFG_IDX_W;
  localparam int unsigned TRACK_W       = POS_W + 2;
  localparam int unsigned TAB_STOP      = 8;
  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum {TRAFFIC_FREE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} traffic_mode_t;

  // Tracks the cursor and the screen registers, and holds the results still owed by the unit.
  class cursor_scoreboard;
    ttcc_pkg::ttcc_cfg_t    screen;
    logic [POS_W-1:0]       col_now;
    logic [POS_W-1:0]       row_now;
    ttcc_pkg::ttcc_result_t owed_results[$];
    int unsigned            mismatch_count;

    function new();
      screen.last_column       = ttcc_pkg::LAST_COLUMN_RST;
      screen.last_row          = ttcc_pkg::LAST_ROW_RST;
      screen.clear_before_draw = 1'b0;
      col_now                  = '0;
      row_now                  = '0;
      mismatch_count           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
      case (idx)
        ttcc_pkg::CFG_LAST_COLUMN:       screen.last_column = data;
        ttcc_pkg::CFG_LAST_ROW:          screen.last_row = data;
        ttcc_pkg::CFG_CLEAR_BEFORE_DRAW: screen.clear_before_draw = data[0];
        default: ;
      endcase
    endfunction

    // Moves the cursor for one byte. Column and row are kept two bits wider than the
    // ports so that a step past 255 wraps or scrolls instead of rolling over.
    function ttcc_pkg::ttcc_result_t advance_cursor(logic [CHAR_W-1:0] code);
      ttcc_pkg::ttcc_result_t res;
      logic [TRACK_W-1:0] col;
      logic [TRACK_W-1:0] row;
      res = '0;
      res.glyph_code = code;
      col = {2'b00, col_now};
      row = {2'b00, row_now};
      if (code >= ttcc_pkg::PRINT_LOW && code <= ttcc_pkg::PRINT_HIGH) begin
        res.draw_glyph    = 1'b1;
        res.clear_cell    = screen.clear_before_draw;
        res.target_column = col_now;
        res.target_row    = row_now;
        col = col + TRACK_W'(1);
      end else if (code == ttcc_pkg::CODE_LINE_FEED) begin
        col = '0;
        row = row + TRACK_W'(1);
      end else if (code == ttcc_pkg::CODE_RETURN) begin
        col = '0;
      end else if (code == ttcc_pkg::CODE_BACKSPACE) begin
        if (col != 0) begin
          col = col - TRACK_W'(1);
        end else if (row != 0) begin
          row = row - TRACK_W'(1);
          col = {2'b00, screen.last_column};
        end
      end else if (code == ttcc_pkg::CODE_TAB) begin
        col = col + TRACK_W'(TAB_STOP - (col % TAB_STOP));
      end
      // Wrap past the right edge, then hold on the bottom row and scroll.
      if (col > screen.last_column) begin
        col = '0;
        row = row + TRACK_W'(1);
      end
      if (row > screen.last_row) begin
        row = {2'b00, screen.last_row};
        res.scroll_up = 1'b1;
      end
      // Backspace clears the cell under the new cursor.
      if (code == ttcc_pkg::CODE_BACKSPACE) begin
        res.clear_cell    = 1'b1;
        res.target_column = col[POS_W-1:0];
        res.target_row    = row[POS_W-1:0];
      end
      col_now = col[POS_W-1:0];
      row_now = row[POS_W-1:0];
      res.cursor_column = col_now;
      res.cursor_row    = row_now;
      return res;
    endfunction

    function void note_char(logic [CHAR_W-1:0] code);
      owed_results.push_back(advance_cursor(code));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(ttcc_pkg::ttcc_result_t got);
      ttcc_pkg::ttcc_result_t want;
      if (owed_results.size() == 0) begin
        $error("result transaction with nothing outstanding: cursor_column actual %0d",
               got.cursor_column);
        mismatch_count++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("draw_glyph", {7'd0, want.draw_glyph}, {7'd0, got.draw_glyph});
      compare_field("glyph_code", want.glyph_code, got.glyph_code);
      compare_field("clear_cell", {7'd0, want.clear_cell}, {7'd0, got.clear_cell});
      compare_field("target_column", want.target_column, got.target_column);
      compare_field("target_row", want.target_row, got.target_row);
      compare_field("scroll_up", {7'd0, want.scroll_up}, {7'd0, got.scroll_up});
      compare_field("cursor_column", want.cursor_column, got.cursor_column);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_draw_glyph;
  logic [CHAR_W-1:0]    out_glyph_code;
  logic                 out_clear_cell;
  logic [POS_W-1:0]     out_target_column;
  logic [POS_W-1:0]     out_target_row;
  logic                 out_scroll_up;
  logic [POS_W-1:0]     out_cursor_column;
  logic [POS_W-1:0]     out_cursor_row;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]     cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  cursor_scoreboard sb = new();

  text_terminal_cursor_control_unit #(.TAB_STOP(TAB_STOP)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_draw_glyph    (out_draw_glyph),
    .out_glyph_code    (out_glyph_code),
    .out_clear_cell    (out_clear_cell),
    .out_target_column (out_target_column),
    .out_target_row    (out_target_row),
    .out_scroll_up     (out_scroll_up),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver stalls at random; the stall is settled at the edge and sampled mid-cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Outputs are stable at the falling edge; a result taken at the next rising edge is checked.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{draw_glyph: out_draw_glyph, glyph_code: out_glyph_code,
                        clear_cell: out_clear_cell, target_column: out_target_column,
                        target_row: out_target_row, scroll_up: out_scroll_up,
                        cursor_column: out_cursor_column, cursor_row: out_cursor_row});
    end
  end

  // Sends one byte after a random gap; returns at the rising edge that takes it.
  task automatic send_char(logic [CHAR_W-1:0] code);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) sb.note_char(code);
      @(posedge clk);
    end while (!taken);
  endtask

  // Stops sending until every owed result has come out, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register; cfg_valid stays high so that writes can follow back to back.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      if (taken) sb.write_reg(idx, data);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic configure(logic [POS_W-1:0] last_col, logic [POS_W-1:0] last_row,
                           logic [POS_W-1:0] clear_data);
    write_cfg(ttcc_pkg::CFG_LAST_COLUMN, last_col);
    write_cfg(ttcc_pkg::CFG_LAST_ROW, last_row);
    write_cfg(ttcc_pkg::CFG_CLEAR_BEFORE_DRAW, clear_data);
    cfg_valid <= 1'b0;
  endtask

  // Mostly text and cursor controls, with some arbitrary bytes mixed in.
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CHAR_W'($urandom_range(ttcc_pkg::PRINT_HIGH, ttcc_pkg::PRINT_LOW));
    if (r < 65) return ttcc_pkg::CODE_LINE_FEED;
    if (r < 72) return ttcc_pkg::CODE_RETURN;
    if (r < 80) return ttcc_pkg::CODE_BACKSPACE;
    if (r < 88) return ttcc_pkg::CODE_TAB;
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic run_phase(logic [POS_W-1:0] last_col, logic [POS_W-1:0] last_row,
                           logic [POS_W-1:0] clear_data, traffic_mode_t mode,
                           int unsigned count);
    drain();
    configure(last_col, last_row, clear_data);
    case (mode)
      TRAFFIC_FREE:   begin idle_pct = 0;  stall_pct = 0;  end
      SENDER_IDLE:    begin idle_pct = 82; stall_pct = 0;  end
      RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 82; end
      BOTH_IDLE:      begin idle_pct = 13; stall_pct = 13; end
    endcase
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(149) == 0) drain();
      send_char(pick_char());
    end
  endtask

  // Overall time limit for the run.
  initial begin
    #5_000_000;
    $display("text_terminal_cursor_control_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An unused register index must change nothing; then the reset values are written back.
    write_cfg(CFG_UNUSED, POS_W'($urandom_range(255)));
    configure(ttcc_pkg::LAST_COLUMN_RST, ttcc_pkg::LAST_ROW_RST, 8'h00);

    // Backspace at the top left, the printable edges, and bytes that move nothing.
    send_char(ttcc_pkg::CODE_BACKSPACE);
    send_char(ttcc_pkg::PRINT_LOW);
    send_char(ttcc_pkg::PRINT_HIGH);
    send_char(8'h1F);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(8'h00);
    // Tabs, return, and backspace at column 0 going up to the last column.
    send_char(ttcc_pkg::CODE_TAB);
    send_char(ttcc_pkg::CODE_TAB);
    send_char(ttcc_pkg::CODE_RETURN);
    send_char(ttcc_pkg::CODE_LINE_FEED);
    send_char(ttcc_pkg::CODE_BACKSPACE);
    send_char(8'h41);
    send_char(ttcc_pkg::CODE_TAB);

    // One-column screen: every advance wraps to a new row; clearing is on.
    drain();
    configure(8'd0, 8'd255, 8'hFF);
    send_char(8'h42);
    send_char(ttcc_pkg::CODE_TAB);
    send_char(ttcc_pkg::CODE_BACKSPACE);
    send_char(ttcc_pkg::CODE_LINE_FEED);

    // A single row with the cursor below it, then tabs past column 255.
    drain();
    configure(8'd255, 8'd0, 8'hFE);
    send_char(8'h05);
    repeat (32) send_char(ttcc_pkg::CODE_TAB);

    // Random phases over several screen shapes and traffic patterns.
    run_phase(ttcc_pkg::LAST_COLUMN_RST, ttcc_pkg::LAST_ROW_RST, 8'h00, TRAFFIC_FREE, 200);
    run_phase(8'd7, 8'd3, 8'h01, SENDER_IDLE, 200);
    run_phase(8'd0, 8'd255, 8'h00, RECEIVER_STALL, 400);
    run_phase(8'd255, 8'd255, 8'h01, BOTH_IDLE, 150);
    run_phase(8'd1, 8'd1, 8'h02, TRAFFIC_FREE, 150);
    run_phase(8'd15, 8'd0, 8'h01, RECEIVER_STALL, 200);
    run_phase(POS_W'($urandom_range(255)), POS_W'($urandom_range(40)),
              POS_W'($urandom_range(255)), SENDER_IDLE, 150);
    run_phase(POS_W'($urandom_range(40)), POS_W'($urandom_range(255)),
              POS_W'($urandom_range(255)), BOTH_IDLE, 150);

    drain();
    if (sb.mismatch_count == 0) begin
      $display("text_terminal_cursor_control_unit: match");
    end else begin
      $display("text_terminal_cursor_control_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
design/ttcc_pkg.sv
design/ttcc_step.sv
design/text_terminal_cursor_control_unit.sv
dv/tb_top.sv
